>>> sv/qglv_pkg.sv
// Shared widths, types, constants and the divide-by-three digit step for
// the quad4 gravity load pipeline. No dependencies.
package qglv_pkg;

    localparam int NODES    = 4;
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Geometry: corner sums, their products, Jacobian terms, Gauss sums
    localparam int SUM_W    = COORD_W + 2;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int DET_W    = PROD_W + 2;
    localparam int TSUM_W   = DET_W + 2;

    // Scaling by density * gravity, split into partial products
    localparam int PMAG_W   = 2 * CFG_W;
    localparam int PSLICE_W = 32;
    localparam int TSLICE_W = 24;
    localparam int P_SLICES = PMAG_W / PSLICE_W;
    localparam int T_SLICES = TSUM_W / TSLICE_W;
    localparam int PP_W     = PSLICE_W + TSLICE_W;
    localparam int HALF_W   = TSUM_W + PSLICE_W;
    localparam int SCALE_W  = HALF_W + PSLICE_W;

    // Q24.24 result is the product / (48 * 2^64 / 2^24) = product / (3 * 2^44)
    localparam int FRAC_SHIFT = 44;
    localparam int MQ_W       = SCALE_W - FRAC_SHIFT;
    localparam int FORCE_W    = 48;

    // Divide by three, one hex digit per step
    localparam int DIV_W         = 52;
    localparam int NIB_CNT       = DIV_W / 4;
    localparam int DIV_STAGES    = 3;
    localparam int NIB_PER_STAGE = (NIB_CNT + DIV_STAGES - 1) / DIV_STAGES;

    localparam logic [SCALE_W-1:0] ROUND_BIAS = SCALE_W'(3) << (FRAC_SHIFT - 1);
    localparam logic [MQ_W-1:0]    SAT_POS_M  = MQ_W'(3) << (FORCE_W - 1);
    localparam logic [MQ_W-1:0]    SAT_NEG_M  = (MQ_W'(3) << (FORCE_W - 1)) + MQ_W'(3);
    localparam logic [FORCE_W-1:0] FORCE_MAX  = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN  = {1'b1, {(FORCE_W-1){1'b0}}};

    // Corner natural coordinates: 1:(-,-) 2:(+,-) 3:(+,+) 4:(-,+); bit k is corner k+1
    localparam logic [NODES-1:0] XI_POS  = 4'b0110;
    localparam logic [NODES-1:0] ETA_POS = 4'b1100;

    localparam logic [CFG_W-1:0] DENSITY_RST = 32'd65536;
    localparam logic [CFG_W-1:0] GRAVITY_RST = 32'd642908;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DENSITY = 1'b0,
        CFG_GRAVITY = 1'b1
    } cfg_reg_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic signed [TSUM_W-1:0]  tsum_t;
    typedef logic [TSUM_W-1:0]         tmag_t;
    typedef logic [DIV_W-1:0]          dval_t;
    typedef logic signed [FORCE_W-1:0] force_t;

    typedef struct packed {
        logic [NODES-1:0] neg;
        logic [NODES-1:0] sat;
    } corner_flags_t;

    // One radix-16 long division step by three: returns {quotient digit, remainder}
    function automatic logic [5:0] div3_nib(input logic [1:0] rem, input logic [3:0] nib);
        logic [2:0] cur;
        logic [1:0] r;
        logic [3:0] q;
        r = rem;
        q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            cur = {r, nib[i]};
            if (cur >= 3'd3)
            begin
                q[i] = 1'b1;
                r    = 2'(cur - 3'd3);
            end
            else
            begin
                q[i] = 1'b0;
                r    = cur[1:0];
            end
        end
        return {q, r};
    endfunction

endpackage

>>> sv/qglv_geom.sv
// Geometry front end: corner sums, Jacobian cross products and the four
// Gauss-weighted determinant sums, as magnitude and sign. Uses qglv_pkg.
module qglv_geom
    import qglv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  coord_t           x [NODES],
    input  coord_t           y [NODES],
    output logic             out_valid,
    input  logic             out_ready,
    output tmag_t            tmag [NODES],
    output logic [NODES-1:0] tneg
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES:0]   rdy;

    sum_t  xe [NODES];
    sum_t  ye [NODES];
    sum_t  ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    sum_t  ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    prod_t p_axby_reg, p_bxay_reg, p_axcy_reg, p_cxay_reg, p_cxby_reg, p_bxcy_reg;
    prod_t p_axby_next, p_bxay_next, p_axcy_next, p_cxay_next, p_cxby_next, p_bxcy_next;
    det_t  d0_reg, d1_reg, d2_reg;
    det_t  d0_next, d1_next, d2_next;
    tsum_t d0w, d1w, d2w, d0x3;
    tsum_t t_reg [NODES];
    tsum_t t_next [NODES];
    tmag_t tmag_reg [NODES];
    tmag_t tmag_next [NODES];
    logic [NODES-1:0] tneg_reg, tneg_next;

    // A stage takes a new request when empty or when it moves on
    assign rdy[STAGES] = out_ready;
    for (genvar s = 0; s < STAGES; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (rdy[s])
                vld_next[s] = (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
            else
                vld_next[s] = vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: edge and twist combinations of the corner coordinates
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
        begin
            xe[k] = SUM_W'(x[k]);
            ye[k] = SUM_W'(y[k]);
        end
        ax_next = -xe[0] + xe[1] + xe[2] - xe[3];
        bx_next = -xe[0] - xe[1] + xe[2] + xe[3];
        cx_next =  xe[0] - xe[1] + xe[2] - xe[3];
        ay_next = -ye[0] + ye[1] + ye[2] - ye[3];
        by_next = -ye[0] - ye[1] + ye[2] + ye[3];
        cy_next =  ye[0] - ye[1] + ye[2] - ye[3];
    end

    // Stage 2: six cross products
    always_comb
    begin
        p_axby_next = prod_t'(ax_reg) * prod_t'(by_reg);
        p_bxay_next = prod_t'(bx_reg) * prod_t'(ay_reg);
        p_axcy_next = prod_t'(ax_reg) * prod_t'(cy_reg);
        p_cxay_next = prod_t'(cx_reg) * prod_t'(ay_reg);
        p_cxby_next = prod_t'(cx_reg) * prod_t'(by_reg);
        p_bxcy_next = prod_t'(bx_reg) * prod_t'(cy_reg);
    end

    // Stage 3: determinant terms
    always_comb
    begin
        d0_next = DET_W'(p_axby_reg) - DET_W'(p_bxay_reg);
        d1_next = DET_W'(p_axcy_reg) - DET_W'(p_cxay_reg);
        d2_next = DET_W'(p_cxby_reg) - DET_W'(p_bxcy_reg);
    end

    // Stage 4: closed-form Gauss sum per corner, 3*D0 +- D1 +- D2
    always_comb
    begin
        d0w  = TSUM_W'(d0_reg);
        d1w  = TSUM_W'(d1_reg);
        d2w  = TSUM_W'(d2_reg);
        d0x3 = (d0w <<< 1) + d0w;
        for (int k = 0; k < NODES; k++)
            t_next[k] = d0x3 + (XI_POS[k] ? d1w : -d1w) + (ETA_POS[k] ? d2w : -d2w);
    end

    // Stage 5: split into magnitude and sign
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
        begin
            tneg_next[k] = t_reg[k][TSUM_W-1];
            tmag_next[k] = tneg_next[k] ? tmag_t'(-t_reg[k]) : tmag_t'(t_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ax_reg <= ax_next;
            bx_reg <= bx_next;
            cx_reg <= cx_next;
            ay_reg <= ay_next;
            by_reg <= by_next;
            cy_reg <= cy_next;
        end
        if (rdy[1])
        begin
            p_axby_reg <= p_axby_next;
            p_bxay_reg <= p_bxay_next;
            p_axcy_reg <= p_axcy_next;
            p_cxay_reg <= p_cxay_next;
            p_cxby_reg <= p_cxby_next;
            p_bxcy_reg <= p_bxcy_next;
        end
        if (rdy[2])
        begin
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
        if (rdy[3])
            t_reg <= t_next;
        if (rdy[4])
        begin
            tmag_reg <= tmag_next;
            tneg_reg <= tneg_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign tmag      = tmag_reg;
    assign tneg      = tneg_reg;

endmodule

>>> sv/qglv_scale.sv
// Scaling back end: multiplies each Gauss sum by density * gravity in
// partial products, rounds and checks the saturation bound. Uses qglv_pkg.
module qglv_scale
    import qglv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tmag_t             tmag [NODES],
    input  logic [NODES-1:0]  tneg,
    input  logic [PMAG_W-1:0] pmag,
    input  logic              pneg,
    output logic              out_valid,
    input  logic              out_ready,
    output dval_t             m [NODES],
    output corner_flags_t     flags
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES:0]   rdy;

    logic [PP_W-1:0]    pp_reg  [NODES][P_SLICES][T_SLICES];
    logic [PP_W-1:0]    pp_next [NODES][P_SLICES][T_SLICES];
    logic [HALF_W-1:0]  half_reg  [NODES][P_SLICES];
    logic [HALF_W-1:0]  half_next [NODES][P_SLICES];
    logic [SCALE_W-1:0] s_reg  [NODES];
    logic [SCALE_W-1:0] s_next [NODES];
    logic [MQ_W-1:0]    mq [NODES];
    dval_t              m_reg  [NODES];
    dval_t              m_next [NODES];
    logic [NODES-1:0]   neg6_reg, neg6_next, neg7_reg, neg8_reg;
    corner_flags_t      flags_reg, flags_next;

    assign rdy[STAGES] = out_ready;
    for (genvar s = 0; s < STAGES; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (rdy[s])
                vld_next[s] = (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
            else
                vld_next[s] = vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: 32x24 partial products of |density*gravity| and |sum|
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
        begin
            for (int i = 0; i < P_SLICES; i++)
                for (int j = 0; j < T_SLICES; j++)
                    pp_next[k][i][j] = PP_W'(pmag[i*PSLICE_W +: PSLICE_W])
                                     * PP_W'(tmag[k][j*TSLICE_W +: TSLICE_W]);
            neg6_next[k] = tneg[k] ^ pneg;
        end
    end

    // Stage 2: gather the partial products of each pmag half
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
            for (int i = 0; i < P_SLICES; i++)
            begin
                half_next[k][i] = '0;
                for (int j = 0; j < T_SLICES; j++)
                    half_next[k][i] = half_next[k][i]
                                    + (HALF_W'(pp_reg[k][i][j]) << (j*TSLICE_W));
            end
    end

    // Stage 3: full magnitude plus half a result step for rounding
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
            s_next[k] = SCALE_W'(half_reg[k][0])
                      + (SCALE_W'(half_reg[k][1]) << PSLICE_W)
                      + ROUND_BIAS;
    end

    // Stage 4: drop the fraction and flag results beyond the 48-bit range
    always_comb
    begin
        flags_next.neg = neg8_reg;
        for (int k = 0; k < NODES; k++)
        begin
            mq[k] = s_reg[k][SCALE_W-1:FRAC_SHIFT];
            flags_next.sat[k] = neg8_reg[k] ? (mq[k] >= SAT_NEG_M) : (mq[k] >= SAT_POS_M);
            m_next[k] = mq[k][DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pp_reg   <= pp_next;
            neg6_reg <= neg6_next;
        end
        if (rdy[1])
        begin
            half_reg <= half_next;
            neg7_reg <= neg6_reg;
        end
        if (rdy[2])
        begin
            s_reg    <= s_next;
            neg8_reg <= neg7_reg;
        end
        if (rdy[3])
        begin
            m_reg     <= m_next;
            flags_reg <= flags_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign m         = m_reg;
    assign flags     = flags_reg;

endmodule

>>> sv/qglv_div3.sv
// Pipelined divide by three of the scaled magnitudes, a few hex digits per
// stage, most significant first. Uses qglv_pkg (div3_nib).
module qglv_div3
    import qglv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dval_t         m [NODES],
    input  corner_flags_t flags_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [FORCE_W-1:0] q [NODES],
    output corner_flags_t flags_out
);

    localparam int STAGES = DIV_STAGES;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES:0]   rdy;

    dval_t         dm_reg    [STAGES][NODES];
    dval_t         dm_next   [STAGES][NODES];
    dval_t         dq_reg    [STAGES][NODES];
    dval_t         dq_next   [STAGES][NODES];
    logic [1:0]    drem_reg  [STAGES][NODES];
    logic [1:0]    drem_next [STAGES][NODES];
    corner_flags_t dflag_reg  [STAGES];
    corner_flags_t dflag_next [STAGES];

    assign rdy[STAGES] = out_ready;
    for (genvar s = 0; s < STAGES; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (rdy[s])
                vld_next[s] = (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
            else
                vld_next[s] = vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Each stage resumes the long division where the previous one stopped
    always_comb
    begin
        dval_t      mm;
        dval_t      qq;
        logic [1:0] r;
        logic [5:0] step;
        int         pos;
        for (int s = 0; s < STAGES; s++)
        begin
            dflag_next[s] = (s == 0) ? flags_in : dflag_reg[(s == 0) ? 0 : s-1];
            for (int k = 0; k < NODES; k++)
            begin
                if (s == 0)
                begin
                    mm = m[k];
                    qq = '0;
                    r  = '0;
                end
                else
                begin
                    mm = dm_reg[s-1][k];
                    qq = dq_reg[s-1][k];
                    r  = drem_reg[s-1][k];
                end
                for (int i = 0; i < NIB_PER_STAGE; i++)
                begin
                    pos = NIB_CNT - 1 - (s*NIB_PER_STAGE + i);
                    if (pos >= 0)
                    begin
                        step = div3_nib(r, mm[4*pos +: 4]);
                        qq[4*pos +: 4] = step[5:2];
                        r = step[1:0];
                    end
                end
                dm_next[s][k]   = mm;
                dq_next[s][k]   = qq;
                drem_next[s][k] = r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (rdy[s])
            begin
                dm_reg[s]    <= dm_next[s];
                dq_reg[s]    <= dq_next[s];
                drem_reg[s]  <= drem_next[s];
                dflag_reg[s] <= dflag_next[s];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NODES; k++)
            q[k] = dq_reg[STAGES-1][k][FORCE_W-1:0];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign flags_out = dflag_reg[STAGES-1];

endmodule

>>> sv/quad4_gravity_load_vector_top.sv
// Top level of the quad4 gravity load pipeline: configuration registers,
// pipeline segments and output register. Uses qglv_pkg, qglv_geom,
// qglv_scale and qglv_div3.
//
// Usage: present the four corner coordinates (Q16.16) with in_valid; a
// request is taken when in_valid and in_ready are both high. The vertical
// nodal loads force1_y..force4_y (Q24.24, saturated, overflow set on any
// clamp) come out with out_valid and are taken when out_ready is high.
// Density and gravity are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no request is in flight.
// There are 5 geometry stages, 4 scaling stages, 3 divide-by-three stages
// and the output register. One request per cycle is sustained while
// out_ready stays high; every stage holds its own valid bit.
// When out_ready is low the pipeline fills its empty stages and then drops
// in_ready; nothing is lost or repeated. Reset empties the pipeline and
// sets density to 1.0 and gravity to 9.81. The density * gravity product
// is re-registered every cycle from the density and gravity registers.
module quad4_gravity_load_vector_top
    import qglv_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   node1_x,
    input  logic signed [COORD_W-1:0]   node2_x,
    input  logic signed [COORD_W-1:0]   node3_x,
    input  logic signed [COORD_W-1:0]   node4_x,
    input  logic signed [COORD_W-1:0]   node1_y,
    input  logic signed [COORD_W-1:0]   node2_y,
    input  logic signed [COORD_W-1:0]   node3_y,
    input  logic signed [COORD_W-1:0]   node4_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FORCE_W-1:0]   force1_y,
    output logic signed [FORCE_W-1:0]   force2_y,
    output logic signed [FORCE_W-1:0]   force3_y,
    output logic signed [FORCE_W-1:0]   force4_y,
    output logic                        overflow
);

    logic [CFG_W-1:0]  density_reg, density_next;
    logic [CFG_W-1:0]  gravity_reg, gravity_next;
    logic [CFG_W-1:0]  gabs;
    logic [PMAG_W-1:0] pmag_reg, pmag_next;
    logic              pneg_reg, pneg_next;

    coord_t           xs [NODES];
    coord_t           ys [NODES];
    tmag_t            tmag [NODES];
    logic [NODES-1:0] tneg;
    logic             geom_valid, scale_ready;
    dval_t            mval [NODES];
    corner_flags_t    scale_flags, div_flags;
    logic             scale_valid, div_ready;
    logic [FORCE_W-1:0] qv [NODES];
    logic             div_valid, ostage_ready;

    logic             out_valid_reg, out_valid_next;
    force_t           force_reg  [NODES];
    force_t           force_next [NODES];
    logic             overflow_reg, overflow_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        density_next = density_reg;
        gravity_next = gravity_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DENSITY: density_next = cfg_data;
                CFG_GRAVITY: gravity_next = cfg_data;
                default:     density_next = density_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= DENSITY_RST;
            gravity_reg <= GRAVITY_RST;
        end
        else
        begin
            density_reg <= density_next;
            gravity_reg <= gravity_next;
        end
    end

    // |density * gravity| and the sign of -(density * gravity)
    always_comb
    begin
        gabs      = gravity_reg[CFG_W-1] ? (~gravity_reg + CFG_W'(1)) : gravity_reg;
        pmag_next = PMAG_W'(density_reg) * PMAG_W'(gabs);
        pneg_next = ~gravity_reg[CFG_W-1];
    end

    always_ff @(posedge clk)
    begin
        pmag_reg <= pmag_next;
        pneg_reg <= pneg_next;
    end

    assign xs[0] = node1_x;
    assign xs[1] = node2_x;
    assign xs[2] = node3_x;
    assign xs[3] = node4_x;
    assign ys[0] = node1_y;
    assign ys[1] = node2_y;
    assign ys[2] = node3_y;
    assign ys[3] = node4_y;

    qglv_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x         (xs),
        .y         (ys),
        .out_valid (geom_valid),
        .out_ready (scale_ready),
        .tmag      (tmag),
        .tneg      (tneg)
    );

    qglv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (scale_ready),
        .tmag      (tmag),
        .tneg      (tneg),
        .pmag      (pmag_reg),
        .pneg      (pneg_reg),
        .out_valid (scale_valid),
        .out_ready (div_ready),
        .m         (mval),
        .flags     (scale_flags)
    );

    qglv_div3 u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (div_ready),
        .m         (mval),
        .flags_in  (scale_flags),
        .out_valid (div_valid),
        .out_ready (ostage_ready),
        .q         (qv),
        .flags_out (div_flags)
    );

    // Output register: apply sign, clamp saturated results
    assign ostage_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = ostage_ready ? div_valid : out_valid_reg;
        overflow_next  = |div_flags.sat;
        for (int k = 0; k < NODES; k++)
        begin
            if (div_flags.sat[k])
                force_next[k] = force_t'(div_flags.neg[k] ? FORCE_MIN : FORCE_MAX);
            else
                force_next[k] = force_t'(div_flags.neg[k] ? (-qv[k]) : qv[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ostage_ready)
        begin
            force_reg    <= force_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign force1_y  = force_reg[0];
    assign force2_y  = force_reg[1];
    assign force3_y  = force_reg[2];
    assign force4_y  = force_reg[3];
    assign overflow  = overflow_reg;

endmodule

>>> dv/tb_quad4_gravity_load_vector_top.sv
// Self-checking testbench for quad4_gravity_load_vector_top: exact-arithmetic
// load predictor in a small tracker class, burst sender, stalling receiver.
// Depends on qglv_pkg and the top level RTL.
import qglv_pkg::*;

typedef logic [NODES-1:0][COORD_W-1:0] corner_set_t;

typedef struct packed {
    logic [NODES-1:0][FORCE_W-1:0] load;
    logic                          ovf;
} load_set_t;

class nodal_load_tracker;
    localparam int WIDE_W = 160;
    localparam logic [WIDE_W-1:0] HALF_STEP = WIDE_W'(3) << (FRAC_SHIFT - 1);

    logic [CFG_W-1:0]        density;
    logic signed [CFG_W-1:0] gravity;
    load_set_t               pending_loads [$];
    int unsigned             mismatches;
    int unsigned             failures;

    function new();
        density     = DENSITY_RST;
        gravity     = GRAVITY_RST;
        mismatches  = 0;
        failures    = 0;
    endfunction

    // Gauss sum in closed form: per corner 3*D0 +- D1 +- D2, scaled by
    // -density*gravity, then divided by 3*2^44 with rounding away from zero.
    function load_set_t compute_nodal_loads(corner_set_t xs, corner_set_t ys);
        logic signed [WIDE_W-1:0] xw [NODES];
        logic signed [WIDE_W-1:0] yw [NODES];
        logic signed [WIDE_W-1:0] ax, bx, cx, ay, by, cy;
        logic signed [WIDE_W-1:0] d0, d1, d2, dens_w, grav_w, weight, tsum, prod;
        logic [WIDE_W-1:0]        mag, quo;
        logic [FORCE_W-1:0]       limit;
        logic                     neg;
        load_set_t                res;
        for (int k = 0; k < NODES; k++)
        begin
            xw[k] = $signed(xs[k]);
            yw[k] = $signed(ys[k]);
        end
        ax = -xw[0] + xw[1] + xw[2] - xw[3];
        bx = -xw[0] - xw[1] + xw[2] + xw[3];
        cx =  xw[0] - xw[1] + xw[2] - xw[3];
        ay = -yw[0] + yw[1] + yw[2] - yw[3];
        by = -yw[0] - yw[1] + yw[2] + yw[3];
        cy =  yw[0] - yw[1] + yw[2] - yw[3];
        d0 = ax * by - bx * ay;
        d1 = ax * cy - cx * ay;
        d2 = cx * by - bx * cy;
        dens_w = density;
        grav_w = gravity;
        weight = -(dens_w * grav_w);
        res.ovf = 1'b0;
        for (int k = 0; k < NODES; k++)
        begin
            tsum = 3 * d0;
            tsum = XI_POS[k] ? tsum + d1 : tsum - d1;
            tsum = ETA_POS[k] ? tsum + d2 : tsum - d2;
            prod = weight * tsum;
            neg  = prod[WIDE_W-1];
            mag  = neg ? -prod : prod;
            quo  = ((mag + HALF_STEP) >> FRAC_SHIFT) / 3;
            limit = neg ? FORCE_MIN : FORCE_MAX;
            if (quo > WIDE_W'(limit))
            begin
                quo     = WIDE_W'(limit);
                res.ovf = 1'b1;
            end
            res.load[k] = neg ? -quo[FORCE_W-1:0] : quo[FORCE_W-1:0];
        end
        return res;
    endfunction

    function void note_request(corner_set_t xs, corner_set_t ys);
        pending_loads.push_back(compute_nodal_loads(xs, ys));
    endfunction

    function int pending_count();
        return pending_loads.size();
    endfunction

    function void check_result(load_set_t got);
        load_set_t want;
        if (pending_loads.size() == 0)
        begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %h %h %h %h ovf %b",
                         got.load[0], got.load[1], got.load[2], got.load[3], got.ovf);
        end
        else
        begin
            want = pending_loads.pop_front();
            if (want != got)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("load mismatch: expected %h %h %h %h ovf %b, got %h %h %h %h ovf %b",
                             want.load[0], want.load[1], want.load[2], want.load[3], want.ovf,
                             got.load[0], got.load[1], got.load[2], got.load[3], got.ovf);
            end
        end
    endfunction

    function void close_out();
        if (pending_loads.size() != 0)
        begin
            failures += pending_loads.size();
            $display("%0d expected load sets never arrived", pending_loads.size());
        end
    endfunction
endclass

module tb_quad4_gravity_load_vector_top;

    localparam int PIPE_LATENCY     = 13;
    localparam int LONG_HOLD        = 150;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 100;
    localparam logic signed [COORD_W-1:0] ONE   = 32'sd65536;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;

    typedef enum int {
        SHAPE_RAW,
        SHAPE_QUAD,
        SHAPE_SMALL,
        SHAPE_FLAT,
        SHAPE_EDGE
    } shape_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  node1_x, node2_x, node3_x, node4_x;
    logic signed [COORD_W-1:0]  node1_y, node2_y, node3_y, node4_y;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [FORCE_W-1:0]  force1_y, force2_y, force3_y, force4_y;
    logic                       overflow;

    nodal_load_tracker tracker;
    int  burst_left;
    bit  offering;
    logic holding;
    int  results_seen;
    int  idle_cycles;

    quad4_gravity_load_vector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .node1_x   (node1_x),
        .node2_x   (node2_x),
        .node3_x   (node3_x),
        .node4_x   (node4_x),
        .node1_y   (node1_y),
        .node2_y   (node2_y),
        .node3_y   (node3_y),
        .node4_y   (node4_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .force1_y  (force1_y),
        .force2_y  (force2_y),
        .force3_y  (force3_y),
        .force4_y  (force4_y),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic corner_set_t corners(input logic [COORD_W-1:0] c1, input logic [COORD_W-1:0] c2,
                                            input logic [COORD_W-1:0] c3, input logic [COORD_W-1:0] c4);
        return {c4, c3, c2, c1};
    endfunction

    function automatic logic [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic build_element(output corner_set_t xs, output corner_set_t ys);
        shape_t      shape;
        int unsigned pick, half;
        int          ctr_x, ctr_y, dir_x, dir_y, jit;
        logic [COORD_W-1:0] tmp;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            shape = SHAPE_RAW;
        else if (pick < 6)
            shape = SHAPE_QUAD;
        else if (pick < 8)
            shape = SHAPE_SMALL;
        else if (pick < 9)
            shape = SHAPE_FLAT;
        else
            shape = SHAPE_EDGE;
        half  = 32'd1 << $urandom_range(8, 28);
        ctr_x = $signed($urandom) >>> $urandom_range(0, 31);
        ctr_y = $signed($urandom) >>> $urandom_range(0, 31);
        dir_x = $signed($urandom) >>> $urandom_range(4, 31);
        dir_y = $signed($urandom) >>> $urandom_range(4, 31);
        for (int k = 0; k < NODES; k++)
        begin
            case (shape)
                SHAPE_RAW:
                begin
                    xs[k] = $urandom;
                    ys[k] = $urandom;
                end
                SHAPE_QUAD:
                begin
                    jit   = int'($urandom_range(0, half >> 1)) - int'(half >> 2);
                    xs[k] = ctr_x + (XI_POS[k] ? int'(half) : -int'(half)) + jit;
                    jit   = int'($urandom_range(0, half >> 1)) - int'(half >> 2);
                    ys[k] = ctr_y + (ETA_POS[k] ? int'(half) : -int'(half)) + jit;
                end
                SHAPE_SMALL:
                begin
                    xs[k] = $signed($urandom) >>> $urandom_range(8, 31);
                    ys[k] = $signed($urandom) >>> $urandom_range(8, 31);
                end
                SHAPE_FLAT:
                begin
                    jit   = int'($urandom_range(0, 6)) - 3;
                    xs[k] = ctr_x + jit * dir_x;
                    ys[k] = ctr_y + jit * dir_y;
                end
                default:
                begin
                    xs[k] = edge_coord();
                    ys[k] = edge_coord();
                end
            endcase
        end
        // swap corners 2 and 4 now and then to invert the element
        if (shape == SHAPE_QUAD && $urandom_range(0, 7) == 0)
        begin
            tmp = xs[1]; xs[1] = xs[3]; xs[3] = tmp;
            tmp = ys[1]; ys[1] = ys[3]; ys[3] = tmp;
        end
    endtask

    task automatic send_element(input corner_set_t xs, input corner_set_t ys);
        in_valid <= 1'b1;
        node1_x  <= xs[0];
        node2_x  <= xs[1];
        node3_x  <= xs[2];
        node4_x  <= xs[3];
        node1_y  <= ys[0];
        node2_y  <= ys[1];
        node3_y  <= ys[2];
        node4_y  <= ys[3];
        offering = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(xs, ys);
        if (burst_left != 0)
            burst_left--;
        // keep offering while the receiver holds off so the pipeline backs up
        if (burst_left == 0 && !holding)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
    endtask

    task automatic quiet_sender();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (tracker.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] dens, input logic [CFG_W-1:0] grav);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DENSITY;
        cfg_data  <= dens;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_GRAVITY;
        cfg_data  <= grav;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.density = dens;
        tracker.gravity = grav;
    endtask

    task automatic choose_settings(input int phase, output logic [CFG_W-1:0] dens,
                                   output logic [CFG_W-1:0] grav);
        case (phase)
            1: begin dens = '0;                   grav = GRAVITY_RST;  end
            2: begin dens = '1;                   grav = 32'h80000000; end
            3: begin dens = DENSITY_RST;          grav = 32'h7FFFFFFF; end
            4: begin dens = '1;                   grav = 32'h7FFFFFFF; end
            5: begin dens = $urandom;             grav = $urandom;     end
            default:
            begin
                dens = $urandom_range(1, 32'h00100000);
                grav = -GRAVITY_RST;
            end
        endcase
    endtask

    task automatic send_directed();
        send_element(corners(0, 0, 0, 0), corners(0, 0, 0, 0));
        send_element(corners(0, ONE, ONE, 0), corners(0, 0, ONE, ONE));
        send_element(corners(0, 0, ONE, ONE), corners(0, ONE, ONE, 0));
        send_element(corners(0, 2 * ONE, 3 * ONE / 2, ONE / 4), corners(0, ONE / 8, ONE, 3 * ONE / 2));
        send_element(corners(0, 2 * ONE, 3 * ONE, ONE), corners(0, 0, ONE, ONE));
        send_element(corners(0, ONE, 2 * ONE, 3 * ONE), corners(0, ONE, 2 * ONE, 3 * ONE));
        send_element(corners(0, ONE, 0, 0), corners(0, 0, ONE, ONE));
        send_element(corners(C_MAX, C_MAX, C_MAX, C_MAX), corners(C_MAX, C_MAX, C_MAX, C_MAX));
        send_element(corners(C_MIN, C_MIN, C_MIN, C_MIN), corners(C_MIN, C_MIN, C_MIN, C_MIN));
        send_element(corners(C_MIN, C_MAX, C_MAX, C_MIN), corners(C_MIN, C_MIN, C_MAX, C_MAX));
        send_element(corners(C_MIN, C_MIN, C_MAX, C_MAX), corners(C_MIN, C_MAX, C_MAX, C_MIN));
        send_element(corners('1, '1, '1, '1), corners('1, '1, '1, '1));
        send_element(corners(0, 1, 1, 0), corners(0, 0, 1, 1));
        send_element(corners(C_MAX - ONE, C_MAX, C_MAX, C_MAX - ONE),
                     corners(C_MIN, C_MIN, C_MIN + ONE, C_MIN + ONE));
        send_element(corners(0, 1 << 24, 1 << 24, 0), corners(0, 0, 1 << 24, 1 << 24));
        send_element(corners(0, 1 << 27, 1 << 27, 0), corners(0, 0, 1 << 27, 1 << 27));
        send_element(corners(0, 1 << 27, 1 << 27, 0), corners(0, 0, -(1 << 27), -(1 << 27)));
    endtask

    // receiver: random ready patterns, plus two long hold-offs
    initial
    begin : receiver
        int pattern, span_left, hold_left, holds_done;
        pattern    = 0;
        span_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        out_ready <= 1'b0;
        holding   <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < 2 && results_seen >= 120 + 300 * holds_done)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                holding   <= 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                holding <= 1'b0;
                if (span_left == 0)
                begin
                    pattern   = $urandom_range(0, 3);
                    span_left = $urandom_range(8, 64);
                end
                span_left--;
                case (pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result({force4_y, force3_y, force2_y, force1_y, overflow});
            results_seen <= results_seen + 1;
        end
    end

    // watchdog: drop the run if no request moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        corner_set_t      xs, ys;
        logic [CFG_W-1:0] dens, grav;
        tracker      = new();
        results_seen = 0;
        idle_cycles  = 0;
        offering     = 1'b0;
        burst_left   = $urandom_range(1, 24);
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DENSITY;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        node1_x   <= '0;
        node2_x   <= '0;
        node3_x   <= '0;
        node4_x   <= '0;
        node1_y   <= '0;
        node2_y   <= '0;
        node3_y   <= '0;
        node4_y   <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                send_directed();
            else
            begin
                wait_drained();
                choose_settings(phase, dens, grav);
                apply_settings(dens, grav);
            end
            repeat (RANDOM_PER_PHASE)
            begin
                build_element(xs, ys);
                send_element(xs, ys);
            end
            quiet_sender();
        end
        wait_drained();
        repeat (PIPE_LATENCY + 8)
            @(posedge clk);
        tracker.close_out();
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/qglv_pkg.sv
sv/qglv_geom.sv
sv/qglv_scale.sv
sv/qglv_div3.sv
sv/quad4_gravity_load_vector_top.sv
dv/tb_quad4_gravity_load_vector_top.sv
